@@ sv/gpl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_pkg
// Shared types, constants and the built-in gradient table of the gradient
// palette lookup.
// ----------------------------------------------------------------------------
package gpl_pkg;

  localparam int PALETTE_SIZE  = 256;
  localparam int MAX_STOPS     = 5;
  localparam int NUM_STOP_REGS = 5;
  localparam int NUM_SEG_SLOTS = NUM_STOP_REGS - 1;
  localparam int NUM_CH        = 3;
  localparam int QUO_W         = 8;
  localparam int REM_W         = 16;
  localparam int APB_ADDR_W    = 6;
  localparam int APB_DATA_W    = 64;

  localparam logic [2:0] PRESET_CUSTOM = 3'd6;
  localparam logic [2:0] CUSTOM_LIMIT  =
    3'(((MAX_STOPS - 1) < NUM_SEG_SLOTS) ? (MAX_STOPS - 1) : NUM_SEG_SLOTS);

  typedef enum logic [2:0] {
    REG_PRESET,
    REG_SEG_COUNT,
    REG_STOP_0,
    REG_STOP_1,
    REG_STOP_2,
    REG_STOP_3,
    REG_STOP_4
  } reg_idx_t;

  typedef struct packed {
    logic [8:0]            pos;
    logic [0:2][7:0]       ch;
  } stop_t;

  typedef struct packed {
    logic [2:0]                      nseg;
    stop_t [0:NUM_STOP_REGS-1]       s;
  } gradient_t;

  typedef struct packed {
    logic                  covered;
    logic [7:0]            off;
    logic [8:0]            span;
    logic [0:2][7:0]       start;
    logic [0:2]            neg;
    logic [0:2][7:0]       mag;
  } s1_t;

  typedef struct packed {
    logic                  covered;
    logic [8:0]            span;
    logic [0:2][7:0]       start;
    logic [0:2]            neg;
    logic [0:2][REM_W-1:0] rem;
    logic [0:2][QUO_W-1:0] quo;
  } div_t;

  function automatic stop_t mk_stop(input logic [8:0] p, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b);
    mk_stop = {p, r, g, b};
  endfunction

  function automatic gradient_t builtin_grad(input logic [2:0] sel);
    gradient_t g;
    g = '0;
    unique case (sel)
      3'd0: begin
        g.nseg = 3'd4;
        g.s[0] = mk_stop(9'd0,   8'd0,   8'd0,   8'd255);
        g.s[1] = mk_stop(9'd64,  8'd0,   8'd255, 8'd255);
        g.s[2] = mk_stop(9'd128, 8'd0,   8'd255, 8'd0);
        g.s[3] = mk_stop(9'd192, 8'd255, 8'd255, 8'd0);
        g.s[4] = mk_stop(9'd256, 8'd255, 8'd0,   8'd0);
      end
      3'd1: begin
        g.nseg = 3'd4;
        g.s[0] = mk_stop(9'd0,   8'd0,   8'd0,   8'd0);
        g.s[1] = mk_stop(9'd32,  8'd26,  8'd2,   8'd112);
        g.s[2] = mk_stop(9'd64,  8'd111, 8'd13,  8'd170);
        g.s[3] = mk_stop(9'd128, 8'd249, 8'd44,  8'd84);
        g.s[4] = mk_stop(9'd256, 8'd247, 8'd255, 8'd175);
      end
      3'd2: begin
        g.nseg = 3'd2;
        g.s[0] = mk_stop(9'd0,   8'd0,   8'd0,   8'd0);
        g.s[1] = mk_stop(9'd96,  8'd249, 8'd44,  8'd84);
        g.s[2] = mk_stop(9'd256, 8'd247, 8'd255, 8'd175);
      end
      3'd3: begin
        g.nseg = 3'd1;
        g.s[0] = mk_stop(9'd0,   8'd19,  8'd95,  8'd64);
        g.s[1] = mk_stop(9'd256, 8'd255, 8'd255, 8'd255);
      end
      3'd4: begin
        g.nseg = 3'd3;
        g.s[0] = mk_stop(9'd0,   8'd0,   8'd0,   8'd0);
        g.s[1] = mk_stop(9'd96,  8'd90,  8'd15,  8'd235);
        g.s[2] = mk_stop(9'd160, 8'd166, 8'd160, 8'd254);
        g.s[3] = mk_stop(9'd256, 8'd238, 8'd172, 8'd255);
      end
      3'd5: begin
        g.nseg = 3'd1;
        g.s[0] = mk_stop(9'd0,   8'd0,   8'd0,   8'd0);
        g.s[1] = mk_stop(9'd256, 8'd255, 8'd255, 8'd255);
      end
      default: g = '0;
    endcase
    builtin_grad = g;
  endfunction

endpackage

@@ sv/gpl_seg_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_seg_select
// First pipeline stage: picks the gradient, finds the segment that holds the
// index and registers offset, span, start colors and channel deltas.
// ----------------------------------------------------------------------------
module gpl_seg_select (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        down_en,
  output logic                                        up_en,
  input  logic                                        in_valid,
  input  logic [7:0]                                  color_index,
  input  logic [2:0]                                  palette_preset,
  input  logic [2:0]                                  segment_count,
  input  gpl_pkg::stop_t [0:gpl_pkg::NUM_STOP_REGS-1] stops,
  output logic                                        valid,
  output gpl_pkg::s1_t                                data
);
  import gpl_pkg::*;

  gradient_t  grad;
  logic       hit;
  logic [1:0] hit_idx;
  stop_t      stop_a;
  stop_t      stop_b;
  logic [8:0] idx_ext;
  logic [8:0] diff;
  s1_t        data_next;

  assign up_en   = !valid || down_en;
  assign idx_ext = {1'b0, color_index};

  always_comb begin
    grad = '0;
    if (palette_preset < PRESET_CUSTOM) begin
      grad = builtin_grad(palette_preset);
    end else if (palette_preset == PRESET_CUSTOM) begin
      grad.nseg = (segment_count > CUSTOM_LIMIT) ? CUSTOM_LIMIT : segment_count;
      grad.s    = stops;
    end
  end

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < NUM_SEG_SLOTS; i++) begin
      if (3'(i) < grad.nseg && idx_ext >= grad.s[i].pos && idx_ext < grad.s[i+1].pos) begin
        hit     = 1'b1;
        hit_idx = 2'(i);
      end
    end
  end

  assign stop_a = grad.s[3'(hit_idx)];
  assign stop_b = grad.s[3'(hit_idx) + 3'd1];

  always_comb begin
    diff              = '0;
    data_next.covered = hit && (idx_ext < 9'(PALETTE_SIZE));
    data_next.off     = 8'(idx_ext - stop_a.pos);
    data_next.span    = stop_b.pos - stop_a.pos;
    data_next.start   = stop_a.ch;
    data_next.neg     = '0;
    data_next.mag     = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      diff             = {1'b0, stop_b.ch[c]} - {1'b0, stop_a.ch[c]};
      data_next.neg[c] = diff[8];
      data_next.mag[c] = diff[8] ? 8'(-diff) : diff[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en) begin
      data <= data_next;
    end
  end

endmodule

@@ sv/gpl_scale.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_scale
// Second pipeline stage: multiplies offset by the delta magnitude and adds the
// rounding bias that turns a truncating division into a floor for falling
// channels.
// ----------------------------------------------------------------------------
module gpl_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          down_en,
  output logic          up_en,
  input  logic          in_valid,
  input  gpl_pkg::s1_t  in_data,
  output logic          valid,
  output gpl_pkg::div_t data
);
  import gpl_pkg::*;

  div_t data_next;

  assign up_en = !valid || down_en;

  always_comb begin
    data_next.covered = in_data.covered;
    data_next.span    = in_data.span;
    data_next.start   = in_data.start;
    data_next.neg     = in_data.neg;
    data_next.quo     = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      data_next.rem[c] = REM_W'(in_data.off) * REM_W'(in_data.mag[c])
                       + (in_data.neg[c] ? (REM_W'(in_data.span) - REM_W'(1)) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_en) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_en) begin
      data <= data_next;
    end
  end

endmodule

@@ sv/gpl_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_divider
// Pipelined restoring divider for the three channels: four register stages,
// each resolving two quotient bits against the segment span.
// ----------------------------------------------------------------------------
module gpl_divider (
  input  logic          clk,
  input  logic          rst,
  input  logic          down_en,
  output logic          up_en,
  input  logic          in_valid,
  input  gpl_pkg::div_t in_data,
  output logic          valid,
  output gpl_pkg::div_t data
);
  import gpl_pkg::*;

  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

  div_t                  stage_in   [0:DIV_STAGES-1];
  logic [0:DIV_STAGES-1] stage_in_v;
  div_t                  stage_q    [1:DIV_STAGES];
  logic [1:DIV_STAGES]   stage_v;
  logic [DIV_STAGES:0]   en;

  function automatic div_t div_step(input div_t d, input int hi);
    div_t             r;
    logic [REM_W-1:0] trial;
    r = d;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        trial = REM_W'(d.span) << (hi - k);
        if (r.rem[c] >= trial) begin
          r.rem[c]               = r.rem[c] - trial;
          r.quo[c][3'(hi - k)]   = 1'b1;
        end
      end
    end
    div_step = r;
  endfunction

  always_comb begin
    stage_in[0]   = in_data;
    stage_in_v[0] = in_valid;
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_in[s]   = stage_q[s];
      stage_in_v[s] = stage_v[s];
    end
  end

  assign en[DIV_STAGES]  = down_en;
  assign up_en           = en[0];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    assign en[s] = !stage_v[s+1] || en[s+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        if (en[s]) begin
          stage_v[s+1] <= stage_in_v[s];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        stage_q[s+1] <= div_step(stage_in[s], QUO_W - 1 - BITS_PER_STAGE * s);
      end
    end
  end

  assign valid = stage_v[DIV_STAGES];
  assign data  = stage_q[DIV_STAGES];

endmodule

@@ sv/gradient_palette_lookup.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_palette_lookup
// Maps an 8-bit index to an RGB color on a piecewise-linear gradient, either
// one of six built-in gradients or up to four custom segments set through the
// APB registers. The block takes one item per clock while in_ready is high:
// one stage finds the segment, one scales the offset, four divider stages
// resolve two quotient bits each, and the output register adds the step to
// the start color. Every stage holds its item while the next one is full, so
// a stall at the output backs up one stage at a time and a new item is still
// taken while a bubble remains in the pipeline. Registers are 64-bit words at
// byte address 8 times their number.
// ----------------------------------------------------------------------------
module gradient_palette_lookup (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gpl_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [gpl_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [gpl_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        color_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        red,
  output logic [7:0]                        green,
  output logic [7:0]                        blue,
  output logic                              covered
);
  import gpl_pkg::*;

  logic [2:0]                     palette_preset;
  logic [2:0]                     segment_count;
  stop_t [0:NUM_STOP_REGS-1]      stops;
  reg_idx_t                       reg_sel;
  logic                           wr_en;

  logic                           seg_valid;
  s1_t                            seg_data;
  logic                           seg_up_en;
  logic                           scale_valid;
  div_t                           scale_data;
  logic                           scale_up_en;
  logic                           div_valid;
  div_t                           div_data;
  logic                           div_up_en;
  logic                           out_en;
  logic [0:2][7:0]                color_next;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_preset <= 3'd0;
      segment_count  <= 3'd4;
      stops          <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_PRESET:    palette_preset <= pwdata[2:0];
        REG_SEG_COUNT: segment_count  <= pwdata[2:0];
        REG_STOP_0:    stops[0]       <= stop_t'(pwdata[32:0]);
        REG_STOP_1:    stops[1]       <= stop_t'(pwdata[32:0]);
        REG_STOP_2:    stops[2]       <= stop_t'(pwdata[32:0]);
        REG_STOP_3:    stops[3]       <= stop_t'(pwdata[32:0]);
        REG_STOP_4:    stops[4]       <= stop_t'(pwdata[32:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PRESET:    prdata = APB_DATA_W'(palette_preset);
      REG_SEG_COUNT: prdata = APB_DATA_W'(segment_count);
      REG_STOP_0:    prdata = APB_DATA_W'(stops[0]);
      REG_STOP_1:    prdata = APB_DATA_W'(stops[1]);
      REG_STOP_2:    prdata = APB_DATA_W'(stops[2]);
      REG_STOP_3:    prdata = APB_DATA_W'(stops[3]);
      REG_STOP_4:    prdata = APB_DATA_W'(stops[4]);
      default:       prdata = '0;
    endcase
  end

  gpl_seg_select u_seg_select (
    .clk            (clk),
    .rst            (rst),
    .down_en        (scale_up_en),
    .up_en          (seg_up_en),
    .in_valid       (in_valid),
    .color_index    (color_index),
    .palette_preset (palette_preset),
    .segment_count  (segment_count),
    .stops          (stops),
    .valid          (seg_valid),
    .data           (seg_data)
  );

  gpl_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .down_en  (div_up_en),
    .up_en    (scale_up_en),
    .in_valid (seg_valid),
    .in_data  (seg_data),
    .valid    (scale_valid),
    .data     (scale_data)
  );

  gpl_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .down_en  (out_en),
    .up_en    (div_up_en),
    .in_valid (scale_valid),
    .in_data  (scale_data),
    .valid    (div_valid),
    .data     (div_data)
  );

  assign in_ready = seg_up_en;
  assign out_en   = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (!div_data.covered) begin
        color_next[c] = '0;
      end else if (div_data.neg[c]) begin
        color_next[c] = div_data.start[c] - div_data.quo[c];
      end else begin
        color_next[c] = div_data.start[c] + div_data.quo[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      red     <= color_next[0];
      green   <= color_next[1];
      blue    <= color_next[2];
      covered <= div_data.covered;
    end
  end

endmodule

@@ sv/gpl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_assertions
// Port-level checks of the gradient palette lookup, bound to the top level.
// ----------------------------------------------------------------------------
module gpl_assertions (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [7:0]                        red,
  input logic [7:0]                        green,
  input logic [7:0]                        blue,
  input logic                              covered
);

  // A reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // When the output can move, every stage can move, so an item can be taken.
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low while the output side can advance");

  // An index outside every segment comes back black.
  a_uncovered_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !covered) |-> (red == 8'd0 && green == 8'd0 && blue == 8'd0))
    else $error("uncovered item with nonzero color");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(red) && $stable(green) && $stable(blue) && $stable(covered)))
    else $error("stalled result changed");

endmodule

bind gradient_palette_lookup gpl_assertions u_gpl_assertions (.*);

@@ dv/gpl_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpl_checker
// Watches the register port and both item channels of the gradient palette
// lookup. It keeps its own copy of the registers, works out the color that
// each accepted index must give, and compares each result, field by field,
// with the oldest color still waiting. Register reads are checked against
// the same copy. It reports the number of failures and of colors still
// waiting.
// ----------------------------------------------------------------------------
module gpl_checker
  import gpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic [APB_DATA_W-1:0] prdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            color_index,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  covered,
  output int                    fail_count,
  output int                    pending
);

  localparam int NUM_BUILTIN = 6;

  typedef struct packed {
    logic [0:2][7:0] rgb;
    logic            covered;
  } color_t;

  int          grad_nseg [NUM_BUILTIN];
  int          grad_pos  [NUM_BUILTIN][NUM_STOP_REGS];
  int          grad_ch   [NUM_BUILTIN][NUM_STOP_REGS][NUM_CH];

  logic [2:0]  preset_reg;
  logic [2:0]  seg_reg;
  logic [32:0] stop_reg [NUM_STOP_REGS];

  color_t      expected_colors [$];
  string       ch_name [NUM_CH] = '{"red", "green", "blue"};

  task automatic put_stop(input int g, input int s, input int p,
                          input int r, input int gr, input int b);
    grad_pos[g][s]   = p;
    grad_ch[g][s][0] = r;
    grad_ch[g][s][1] = gr;
    grad_ch[g][s][2] = b;
  endtask

  initial begin
    grad_nseg[0] = 4;
    put_stop(0, 0, 0,   0,   0,   255);
    put_stop(0, 1, 64,  0,   255, 255);
    put_stop(0, 2, 128, 0,   255, 0);
    put_stop(0, 3, 192, 255, 255, 0);
    put_stop(0, 4, 256, 255, 0,   0);
    grad_nseg[1] = 4;
    put_stop(1, 0, 0,   0,   0,   0);
    put_stop(1, 1, 32,  26,  2,   112);
    put_stop(1, 2, 64,  111, 13,  170);
    put_stop(1, 3, 128, 249, 44,  84);
    put_stop(1, 4, 256, 247, 255, 175);
    grad_nseg[2] = 2;
    put_stop(2, 0, 0,   0,   0,   0);
    put_stop(2, 1, 96,  249, 44,  84);
    put_stop(2, 2, 256, 247, 255, 175);
    grad_nseg[3] = 1;
    put_stop(3, 0, 0,   19,  95,  64);
    put_stop(3, 1, 256, 255, 255, 255);
    grad_nseg[4] = 3;
    put_stop(4, 0, 0,   0,   0,   0);
    put_stop(4, 1, 96,  90,  15,  235);
    put_stop(4, 2, 160, 166, 160, 254);
    put_stop(4, 3, 256, 238, 172, 255);
    grad_nseg[5] = 1;
    put_stop(5, 0, 0,   0,   0,   0);
    put_stop(5, 1, 256, 255, 255, 255);
  end

  function automatic color_t predict_color(input logic [7:0] idx);
    int     pos [NUM_STOP_REGS];
    int     ch  [NUM_STOP_REGS][NUM_CH];
    int     nseg;
    int     hit;
    int     span;
    int     off;
    int     num;
    int     q;
    color_t c;
    c    = '0;
    hit  = -1;
    nseg = 0;
    if (preset_reg == PRESET_CUSTOM) begin
      nseg = (seg_reg > CUSTOM_LIMIT) ? int'(CUSTOM_LIMIT) : int'(seg_reg);
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        pos[k]   = int'(stop_reg[k][32:24]);
        ch[k][0] = int'(stop_reg[k][23:16]);
        ch[k][1] = int'(stop_reg[k][15:8]);
        ch[k][2] = int'(stop_reg[k][7:0]);
      end
    end else if (preset_reg < NUM_BUILTIN) begin
      nseg = grad_nseg[preset_reg];
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        pos[k] = grad_pos[preset_reg][k];
        for (int m = 0; m < NUM_CH; m++) begin
          ch[k][m] = grad_ch[preset_reg][k][m];
        end
      end
    end
    for (int i = 0; i < nseg; i++) begin
      if (pos[i] <= int'(idx) && int'(idx) < pos[i+1]) begin
        hit = i;
      end
    end
    if (hit >= 0) begin
      span = pos[hit+1] - pos[hit];
      off  = int'(idx) - pos[hit];
      for (int m = 0; m < NUM_CH; m++) begin
        num = off * (ch[hit+1][m] - ch[hit][m]);
        q   = (num >= 0) ? num / span : -((-num + span - 1) / span);
        c.rgb[m] = 8'(ch[hit][m] + q);
      end
      c.covered = 1'b1;
    end
    return c;
  endfunction

  always @(posedge clk) begin : sample
    int              errs;
    int              ridx;
    logic [63:0]     reg_word;
    logic [7:0]      seen [NUM_CH];
    color_t          want;
    errs = 0;
    if (rst) begin
      preset_reg = '0;
      seg_reg    = 3'd4;
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        stop_reg[k] = '0;
      end
    end else begin
      if (psel && penable && pready) begin
        ridx = int'(paddr[APB_ADDR_W-1:3]);
        if (pwrite) begin
          if (ridx == REG_PRESET) begin
            preset_reg = pwdata[2:0];
          end else if (ridx == REG_SEG_COUNT) begin
            seg_reg = pwdata[2:0];
          end else if (ridx >= REG_STOP_0 && ridx <= REG_STOP_4) begin
            stop_reg[ridx - REG_STOP_0] = pwdata[32:0];
          end
        end else begin
          reg_word = '0;
          if (ridx == REG_PRESET) begin
            reg_word = 64'(preset_reg);
          end else if (ridx == REG_SEG_COUNT) begin
            reg_word = 64'(seg_reg);
          end else if (ridx >= REG_STOP_0 && ridx <= REG_STOP_4) begin
            reg_word = 64'(stop_reg[ridx - REG_STOP_0]);
          end
          if (prdata !== reg_word) begin
            $error("prdata of register %0d: expected %h, got %h", ridx, reg_word, prdata);
            errs++;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          $error("result with no item waiting: red %0d green %0d blue %0d covered %0b",
                 red, green, blue, covered);
          errs++;
        end else begin
          want    = expected_colors.pop_front();
          seen[0] = red;
          seen[1] = green;
          seen[2] = blue;
          for (int m = 0; m < NUM_CH; m++) begin
            if (seen[m] !== want.rgb[m]) begin
              $error("%s: expected %0d, got %0d", ch_name[m], want.rgb[m], seen[m]);
              errs++;
            end
          end
          if (covered !== want.covered) begin
            $error("covered: expected %0b, got %0b", want.covered, covered);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_colors.push_back(predict_color(color_index));
      end
    end
    fail_count <= fail_count + errs;
    pending    <= expected_colors.size();
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the gradient palette lookup. It programs the registers while
// the block is idle, first with a few directed settings and indexes around
// stop edges, overlaps, empty segments and out-of-range settings, then with
// random gradients and random indexes. Both channels idle at random, and
// twice the receiver holds off long enough for the pipeline to back up. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import gpl_pkg::*;

  localparam int         RESET_CYCLES    = 8;
  localparam int         NUM_BUILTIN     = 6;
  localparam int         NUM_PHASES      = 14;
  localparam int         ITEMS_PER_PHASE = 75;
  localparam int         HOLD_CYCLES     = 200;
  localparam int         DRAIN_CYCLES    = 20;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         REG_NONE        = 7;
  localparam logic [2:0] PRESET_NONE     = 3'd7;
  localparam bit         APB_WRITE       = 1'b1;
  localparam bit         APB_READ        = 1'b0;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            color_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic                  covered;
  int                    fail_count;
  int                    pending;

  bit                    quiet    = 1'b0;
  bit                    hold_req = 1'b0;
  int                    stop_pos_now [NUM_STOP_REGS];

  gradient_palette_lookup uut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .color_index (color_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .covered     (covered)
  );

  gpl_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .color_index (color_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .covered     (covered),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_index();
    int p;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 255));
    p = stop_pos_now[$urandom_range(0, NUM_STOP_REGS - 1)] + int'($urandom_range(0, 2)) - 1;
    return 8'(p);
  endfunction

  // Called and left at a falling edge with the bus idle.
  task automatic apb_access(input bit write, input int idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= APB_ADDR_W'(8 * idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_all_regs();
    for (int r = int'(REG_PRESET); r <= int'(REG_STOP_4); r++) begin
      apb_access(APB_READ, r, '0);
    end
  endtask

  // Valid stays high from one item to the next unless a gap is drawn.
  task automatic send_index(input logic [7:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    color_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic program_random_palette();
    logic [2:0] preset;
    logic [2:0] segs;
    int         kind;
    int         pos;
    int         last;
    kind = $urandom_range(0, 9);
    if (kind < 5) preset = PRESET_CUSTOM;
    else if (kind < 9) preset = 3'($urandom_range(0, NUM_BUILTIN - 1));
    else preset = PRESET_NONE;
    if ($urandom_range(0, 3) == 0) segs = 3'($urandom_range(0, 7));
    else segs = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 4) == 0) begin
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        stop_pos_now[k] = $urandom_range(0, 511);
      end
    end else begin
      pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : 0;
      for (int k = 0; k < NUM_STOP_REGS; k++) begin
        stop_pos_now[k] = pos;
        pos = pos + $urandom_range(1, 96);
        if (pos > 256) pos = 256;
      end
      last = (segs > 4) ? 4 : int'(segs);
      if ($urandom_range(0, 1) == 1) stop_pos_now[last] = 256;
    end
    for (int k = 0; k < NUM_STOP_REGS; k++) begin
      apb_access(APB_WRITE, REG_STOP_0 + k,
                 {31'($urandom), 9'(stop_pos_now[k]), 24'($urandom)});
    end
    apb_access(APB_WRITE, REG_SEG_COUNT, {32'($urandom), 29'($urandom), segs});
    apb_access(APB_WRITE, REG_PRESET, {32'($urandom), 29'($urandom), preset});
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    color_index = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    read_all_regs();
    send_index(8'd0);
    send_index(8'd63);
    send_index(8'd64);
    send_index(8'd128);
    send_index(8'd191);
    send_index(8'd192);
    send_index(8'd255);
    finish_burst();

    // Segment 1 is reversed, segment 3 is empty and segment 2 overlaps
    // segment 0 from 100 to 199, where it must win.
    apb_access(APB_WRITE, REG_STOP_0, {31'h7fffffff, 9'd0,   8'd255, 8'd255, 8'd255});
    apb_access(APB_WRITE, REG_STOP_1, {31'd0,        9'd200, 8'd0,   8'd0,   8'd0});
    apb_access(APB_WRITE, REG_STOP_2, {31'h2aaaaaaa, 9'd100, 8'd10,  8'd200, 8'd30});
    apb_access(APB_WRITE, REG_STOP_3, {31'd0,        9'd256, 8'd250, 8'd5,   8'd100});
    apb_access(APB_WRITE, REG_STOP_4, {31'd0,        9'd256, 8'd1,   8'd2,   8'd3});
    apb_access(APB_WRITE, REG_SEG_COUNT, 64'd4);
    apb_access(APB_WRITE, REG_PRESET, 64'(PRESET_CUSTOM));
    send_index(8'd0);
    send_index(8'd99);
    send_index(8'd100);
    send_index(8'd150);
    send_index(8'd200);
    send_index(8'd255);
    finish_burst();

    apb_access(APB_WRITE, REG_SEG_COUNT, 64'hf8);
    send_index(8'd10);
    finish_burst();
    apb_access(APB_WRITE, REG_SEG_COUNT, 64'd7);
    send_index(8'd150);
    finish_burst();
    apb_access(APB_WRITE, REG_NONE, '1);
    send_index(8'd255);
    finish_burst();
    apb_access(APB_WRITE, REG_PRESET, '1);
    send_index(8'd50);
    finish_burst();
    read_all_regs();

    for (int p = 0; p < NUM_PHASES; p++) begin
      quiet = (p % 4 == 1) || (p == 2);
      program_random_palette();
      if (p == 2 || p == 9) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_index(pick_index());
      finish_burst();
      read_all_regs();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : sink
    int stall;
    int run;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      run = $urandom_range(1, quiet ? 40 : 8);
      repeat (run) begin
        @(negedge clk);
        if (hold_req) break;
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("FAIL");
    $finish;
  end

endmodule

@@ gradient_palette_lookup.f @@
sv/gpl_pkg.sv
sv/gpl_seg_select.sv
sv/gpl_scale.sv
sv/gpl_divider.sv
sv/gradient_palette_lookup.sv
sv/gpl_checker.sv
dv/gpl_checker.sv
dv/tb_top.sv
